FILE: rtl/core/acsi_pkg.sv
// ----------------------------------------------------------------------------
// acsi_pkg
// Shared types, constants and lookup functions for the ANSI CSI terminal
// parser.
// ----------------------------------------------------------------------------
package acsi_pkg;

  // Screen geometry and parameter defaults
  localparam int SCREEN_COLS_DEF = 80;
  localparam int SCREEN_ROWS_DEF = 24;
  localparam int MAX_PARAMS_DEF  = 4;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int CMD_W   = 2;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CODE_W  = 7;
  localparam int COLOR_W = 4;

  // Result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // Stream bytes
  localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] BYTE_TILDE = 8'h7E;
  localparam logic [BYTE_W-1:0] BYTE_LBRK  = 8'h5B;
  localparam logic [BYTE_W-1:0] BYTE_SEMI  = 8'h3B;
  localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] BYTE_NINE  = 8'h39;

  // CSI final bytes
  localparam logic [BYTE_W-1:0] FIN_UP    = 8'h41;  // A
  localparam logic [BYTE_W-1:0] FIN_DOWN  = 8'h42;  // B
  localparam logic [BYTE_W-1:0] FIN_RIGHT = 8'h43;  // C
  localparam logic [BYTE_W-1:0] FIN_LEFT  = 8'h44;  // D
  localparam logic [BYTE_W-1:0] FIN_POS   = 8'h48;  // H
  localparam logic [BYTE_W-1:0] FIN_POS_F = 8'h66;  // f
  localparam logic [BYTE_W-1:0] FIN_ERASE = 8'h4A;  // J
  localparam logic [BYTE_W-1:0] FIN_SGR   = 8'h6D;  // m

  // SGR values
  localparam logic [BYTE_W-1:0] SGR_RESET   = 8'd0;
  localparam logic [BYTE_W-1:0] SGR_FG_LO   = 8'd30;
  localparam logic [BYTE_W-1:0] SGR_FG_HI   = 8'd37;
  localparam logic [BYTE_W-1:0] SGR_BFG_LO  = 8'd90;
  localparam logic [BYTE_W-1:0] SGR_BFG_HI  = 8'd97;
  localparam logic [BYTE_W-1:0] ERASE_ALL   = 8'd2;
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 4'd1;

  typedef enum logic [1:0] {
    PH_TEXT  = 2'd0,
    PH_ESC   = 2'd1,
    PH_OPEN  = 2'd2,
    PH_PARAM = 2'd3
  } phase_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_RENDER = 2'd0,
    CMD_SCROLL = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [COL_W-1:0]   glyph_col;
    logic [ROW_W-1:0]   glyph_row;
    logic [CODE_W-1:0]  glyph_code;
    logic [COLOR_W-1:0] glyph_color;
    logic               last_of_run;
  } result_t;

  // SGR color index (0..7 normal, 8..15 bright) to palette index
  function automatic logic [COLOR_W-1:0] color_map(input logic [3:0] idx);
    logic [COLOR_W-1:0] c;
    unique case (idx)
      4'd0:    c = 4'd0;
      4'd1:    c = 4'd2;
      4'd2:    c = 4'd5;
      4'd3:    c = 4'd7;
      4'd4:    c = 4'd6;
      4'd5:    c = 4'd4;
      4'd6:    c = 4'd3;
      4'd7:    c = 4'd1;
      4'd8:    c = 4'd11;
      4'd9:    c = 4'd10;
      4'd10:   c = 4'd13;
      4'd11:   c = 4'd7;
      4'd12:   c = 4'd14;
      4'd13:   c = 4'd4;
      4'd14:   c = 4'd3;
      default: c = 4'd1;
    endcase
    return c;
  endfunction

  // CP437 box drawing and shading folded onto plain ASCII
  function automatic logic [CODE_W-1:0] remap_glyph(input logic [BYTE_W-1:0] b);
    logic [CODE_W-1:0] g;
    if (b >= BYTE_SPACE && b <= BYTE_TILDE)  g = b[CODE_W-1:0];
    else if (b == 8'hB3 || b == 8'hBA)       g = 7'h7C;  // '|'
    else if (b == 8'hC4 || b == 8'hCD)       g = 7'h2D;  // '-'
    else if (b >= 8'hB0 && b <= 8'hB2)       g = 7'h23;  // '#'
    else if (b >= 8'hB4 && b <= 8'hDF)       g = 7'h2B;  // '+'
    else                                     g = 7'h20;  // ' '
    return g;
  endfunction

endpackage

FILE: rtl/core/ansi_csi_terminal_parser_top.sv
// ----------------------------------------------------------------------------
// ansi_csi_terminal_parser_top
// Byte-stream terminal parser: text rendering, cursor control and SGR color.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | dir | per word
//  --------+-----------------------------------------+-----+---------------------
//  in      | in_valid, in_ready, in_byte             | in  | one stream byte
//  out     | out_valid, out_ready, out_command,      | out | one command; 0..2
//          | out_glyph_col/row/code/color,           |     | per byte, last one
//          | out_last_of_run                         |     | flagged
//
//  A byte is parsed in the cycle it is taken; its results enter a four-entry
//  result queue and leave one per cycle while out_ready is high. One byte per
//  cycle sustained while the out side keeps up; a byte with two results
//  (wrap + scroll) yields two words. in_ready is high while the queue has
//  room for two words. Reset (rst_n, synchronous) clears parse state, cursor,
//  color and queue. A stalled out side fills the queue and drops in_ready.
// ----------------------------------------------------------------------------
module ansi_csi_terminal_parser_top #(
  parameter int SCREEN_COLS = acsi_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = acsi_pkg::SCREEN_ROWS_DEF,
  parameter int MAX_PARAMS  = acsi_pkg::MAX_PARAMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [acsi_pkg::BYTE_W-1:0]   in_byte,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [acsi_pkg::CMD_W-1:0]    out_command,
  output logic [acsi_pkg::COL_W-1:0]    out_glyph_col,
  output logic [acsi_pkg::ROW_W-1:0]    out_glyph_row,
  output logic [acsi_pkg::CODE_W-1:0]   out_glyph_code,
  output logic [acsi_pkg::COLOR_W-1:0]  out_glyph_color,
  output logic                          out_last_of_run
);

  // Parameter count must hold MAX_PARAMS itself
  localparam int PCNT_W = $clog2(MAX_PARAMS + 1);
  localparam int BW     = acsi_pkg::BYTE_W;
  localparam int XW     = BW + 1;  // cursor arithmetic with headroom

  localparam logic [acsi_pkg::COL_W-1:0] LAST_COL = acsi_pkg::COL_W'(SCREEN_COLS - 1);
  localparam logic [acsi_pkg::ROW_W-1:0] LAST_ROW = acsi_pkg::ROW_W'(SCREEN_ROWS - 1);
  localparam logic [PCNT_W-1:0]          PCNT_MAX = PCNT_W'(MAX_PARAMS);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  acsi_pkg::phase_t                phase_r, phase_nxt;
  logic [acsi_pkg::COL_W-1:0]      col_r, col_nxt;
  logic [acsi_pkg::ROW_W-1:0]      row_r, row_nxt;
  logic [acsi_pkg::COLOR_W-1:0]    fg_r, fg_nxt;
  logic [BW-1:0]                   params_r   [MAX_PARAMS];
  logic [BW-1:0]                   params_nxt [MAX_PARAMS];
  logic [PCNT_W-1:0]               pcnt_r, pcnt_nxt;
  logic [BW-1:0]                   acc_r, acc_nxt;

  // Result queue
  acsi_pkg::result_t               q_r [acsi_pkg::Q_DEPTH];
  logic [acsi_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [acsi_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [acsi_pkg::Q_CNT_W-1:0]    q_cnt_r, q_cnt_nxt;

  // --------------------------------------------------------------------------
  // Byte classification
  // --------------------------------------------------------------------------
  logic          in_fire, out_fire;
  logic          is_digit, is_semi, is_final;
  logic [BW-1:0] digit_val;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign is_digit  = (in_byte >= acsi_pkg::BYTE_ZERO) && (in_byte <= acsi_pkg::BYTE_NINE);
  assign is_semi   = (in_byte == acsi_pkg::BYTE_SEMI);
  assign is_final  = !is_digit && !is_semi;
  assign digit_val = in_byte - acsi_pkg::BYTE_ZERO;

  // --------------------------------------------------------------------------
  // Effective parameter list: what the list looks like once the pending
  // accumulator is stored by a separator or final byte. Right after ESC [ it
  // is empty. One spare zero entry keeps the column lookup of H in range.
  // --------------------------------------------------------------------------
  logic [BW-1:0]     p_eff [MAX_PARAMS + 1];
  logic [PCNT_W-1:0] cnt_eff;

  always_comb begin
    for (int i = 0; i <= MAX_PARAMS; i++) begin
      p_eff[i] = '0;
    end
    cnt_eff = '0;
    if (phase_r == acsi_pkg::PH_PARAM) begin
      cnt_eff = (pcnt_r < PCNT_MAX) ? pcnt_r + PCNT_W'(1) : pcnt_r;
      for (int i = 0; i < MAX_PARAMS; i++) begin
        p_eff[i] = (pcnt_r == PCNT_W'(i)) ? acc_r : params_r[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Next parse phase
  // --------------------------------------------------------------------------
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      unique case (phase_r)
        acsi_pkg::PH_TEXT: begin
          if (in_byte == acsi_pkg::BYTE_ESC) phase_nxt = acsi_pkg::PH_ESC;
        end
        acsi_pkg::PH_ESC: begin
          phase_nxt = (in_byte == acsi_pkg::BYTE_LBRK) ? acsi_pkg::PH_OPEN
                                                       : acsi_pkg::PH_TEXT;
        end
        acsi_pkg::PH_OPEN,
        acsi_pkg::PH_PARAM: begin
          phase_nxt = is_final ? acsi_pkg::PH_TEXT : acsi_pkg::PH_PARAM;
        end
        default: phase_nxt = acsi_pkg::PH_TEXT;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath: cursor, color, parameters and the results of this byte
  // --------------------------------------------------------------------------
  acsi_pkg::result_t res0, res1;
  logic [1:0]        nres;

  always_comb begin
    logic [BW-1:0]  first_n;
    logic [XW-1:0]  row_x, col_x, n_x, sum_row, sum_col;
    logic [BW-1:0]  pos_r, pos_c;
    logic [BW-1:0]  v;
    logic [BW-1:0]  fg_off, bfg_off;

    first_n = (cnt_eff != '0 && p_eff[0] != '0) ? p_eff[0] : BW'(1);
    row_x   = XW'(row_r);
    col_x   = XW'(col_r);
    n_x     = XW'(first_n);
    sum_row = row_x + n_x;
    sum_col = col_x + n_x;
    pos_r   = (cnt_eff != '0 && p_eff[0] != '0) ? p_eff[0] - BW'(1) : '0;
    pos_c   = (cnt_eff > PCNT_W'(1) && p_eff[1] != '0) ? p_eff[1] - BW'(1) : '0;
    v       = '0;
    fg_off  = '0;
    bfg_off = '0;

    col_nxt  = col_r;
    row_nxt  = row_r;
    fg_nxt   = fg_r;
    pcnt_nxt = pcnt_r;
    acc_nxt  = acc_r;
    for (int i = 0; i < MAX_PARAMS; i++) begin
      params_nxt[i] = params_r[i];
    end
    res0 = '0;
    res1 = '0;
    nres = 2'd0;

    if (in_fire) begin
      unique case (phase_r)
        acsi_pkg::PH_TEXT: begin
          if (in_byte == acsi_pkg::BYTE_CR) begin
            col_nxt = '0;
          end else if (in_byte == acsi_pkg::BYTE_LF) begin
            if (row_r < LAST_ROW) begin
              row_nxt = row_r + acsi_pkg::ROW_W'(1);
            end else begin
              res0.command = acsi_pkg::CMD_SCROLL;
              nres         = 2'd1;
            end
          end else if (in_byte >= acsi_pkg::BYTE_SPACE) begin
            res0.command     = acsi_pkg::CMD_RENDER;
            res0.glyph_col   = col_r;
            res0.glyph_row   = row_r;
            res0.glyph_code  = acsi_pkg::remap_glyph(in_byte);
            res0.glyph_color = fg_r;
            nres             = 2'd1;
            if (col_r >= LAST_COL) begin
              // wrap to next line, scroll on the bottom row
              col_nxt = '0;
              if (row_r < LAST_ROW) begin
                row_nxt = row_r + acsi_pkg::ROW_W'(1);
              end else begin
                res1.command = acsi_pkg::CMD_SCROLL;
                nres         = 2'd2;
              end
            end else begin
              col_nxt = col_r + acsi_pkg::COL_W'(1);
            end
          end
        end

        acsi_pkg::PH_ESC: begin
        end

        acsi_pkg::PH_OPEN,
        acsi_pkg::PH_PARAM: begin
          if (phase_r == acsi_pkg::PH_OPEN) begin
            for (int i = 0; i < MAX_PARAMS; i++) begin
              params_nxt[i] = '0;
            end
            pcnt_nxt = is_semi ? PCNT_W'(1) : '0;
            acc_nxt  = is_digit ? digit_val : '0;
          end else if (is_digit) begin
            acc_nxt = BW'((acc_r << 3) + (acc_r << 1) + digit_val);
          end else begin
            // store pending parameter
            for (int i = 0; i < MAX_PARAMS; i++) begin
              params_nxt[i] = p_eff[i];
            end
            pcnt_nxt = cnt_eff;
            acc_nxt  = '0;
          end

          if (is_final) begin
            priority case (in_byte)
              acsi_pkg::FIN_UP: begin
                row_nxt = (row_x >= n_x) ? acsi_pkg::ROW_W'(row_x - n_x) : '0;
              end
              acsi_pkg::FIN_DOWN: begin
                row_nxt = (sum_row < XW'(SCREEN_ROWS)) ? acsi_pkg::ROW_W'(sum_row)
                                                       : LAST_ROW;
              end
              acsi_pkg::FIN_RIGHT: begin
                col_nxt = (sum_col < XW'(SCREEN_COLS)) ? acsi_pkg::COL_W'(sum_col)
                                                       : LAST_COL;
              end
              acsi_pkg::FIN_LEFT: begin
                col_nxt = (col_x >= n_x) ? acsi_pkg::COL_W'(col_x - n_x) : '0;
              end
              acsi_pkg::FIN_POS,
              acsi_pkg::FIN_POS_F: begin
                row_nxt = (XW'(pos_r) >= XW'(SCREEN_ROWS)) ? LAST_ROW
                                                           : acsi_pkg::ROW_W'(pos_r);
                col_nxt = (XW'(pos_c) >= XW'(SCREEN_COLS)) ? LAST_COL
                                                           : acsi_pkg::COL_W'(pos_c);
              end
              acsi_pkg::FIN_ERASE: begin
                if (cnt_eff == '0 || p_eff[0] == acsi_pkg::ERASE_ALL) begin
                  res0.command = acsi_pkg::CMD_CLEAR;
                  nres         = 2'd1;
                end
              end
              acsi_pkg::FIN_SGR: begin
                if (cnt_eff == '0) begin
                  fg_nxt = acsi_pkg::COLOR_WHITE;
                end else begin
                  // applied in order, last match wins
                  for (int i = 0; i < MAX_PARAMS; i++) begin
                    v       = p_eff[i];
                    fg_off  = v - acsi_pkg::SGR_FG_LO;
                    bfg_off = v - acsi_pkg::SGR_BFG_LO;
                    if (PCNT_W'(i) < cnt_eff) begin
                      if (v == acsi_pkg::SGR_RESET) begin
                        fg_nxt = acsi_pkg::COLOR_WHITE;
                      end else if (v >= acsi_pkg::SGR_FG_LO && v <= acsi_pkg::SGR_FG_HI) begin
                        fg_nxt = acsi_pkg::color_map({1'b0, fg_off[2:0]});
                      end else if (v >= acsi_pkg::SGR_BFG_LO &&
                                   v <= acsi_pkg::SGR_BFG_HI) begin
                        fg_nxt = acsi_pkg::color_map({1'b1, bfg_off[2:0]});
                      end
                    end
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end

        default: begin
        end
      endcase
    end

    if (nres == 2'd1) res0.last_of_run = 1'b1;
    if (nres == 2'd2) res1.last_of_run = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Result queue control
  // --------------------------------------------------------------------------
  assign in_ready = (q_cnt_r <= acsi_pkg::Q_CNT_W'(acsi_pkg::Q_DEPTH - 2));
  assign out_valid = (q_cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + acsi_pkg::Q_PTR_W'(nres);
    rd_ptr_nxt = rd_ptr_r + acsi_pkg::Q_PTR_W'(out_fire);
    q_cnt_nxt  = q_cnt_r + acsi_pkg::Q_CNT_W'(nres) - acsi_pkg::Q_CNT_W'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= acsi_pkg::PH_TEXT;
      col_r    <= '0;
      row_r    <= '0;
      fg_r     <= acsi_pkg::COLOR_WHITE;
      pcnt_r   <= '0;
      acc_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
      for (int i = 0; i < MAX_PARAMS; i++) begin
        params_r[i] <= '0;
      end
    end else begin
      phase_r  <= phase_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      fg_r     <= fg_nxt;
      pcnt_r   <= pcnt_nxt;
      acc_r    <= acc_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
      for (int i = 0; i < MAX_PARAMS; i++) begin
        params_r[i] <= params_nxt[i];
      end
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (nres != 2'd0) q_r[wr_ptr_r] <= res0;
    if (nres == 2'd2) q_r[wr_ptr_r + acsi_pkg::Q_PTR_W'(1)] <= res1;
  end

  // --------------------------------------------------------------------------
  // Output fields
  // --------------------------------------------------------------------------
  acsi_pkg::result_t head;
  assign head            = q_r[rd_ptr_r];
  assign out_command     = head.command;
  assign out_glyph_col   = head.glyph_col;
  assign out_glyph_row   = head.glyph_row;
  assign out_glyph_code  = head.glyph_code;
  assign out_glyph_color = head.glyph_color;
  assign out_last_of_run = head.last_of_run;

endmodule

FILE: test/tb_ansi_csi_terminal_parser_top.sv
// ----------------------------------------------------------------------------
// tb_ansi_csi_terminal_parser_top
// Self-checking bench for the terminal parser. A byte backlog feeds a
// valid/ready driver. Every accepted byte runs through a local screen model
// that predicts the render, scroll and clear words. A monitor under random
// back-pressure checks each output word field by field against the model.
// ----------------------------------------------------------------------------
module tb_ansi_csi_terminal_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  import acsi_pkg::*;

  // Geometry of the instance under test (package defaults)
  localparam int COLS  = SCREEN_COLS_DEF;
  localparam int ROWS  = SCREEN_ROWS_DEF;
  localparam int NARGS = MAX_PARAMS_DEF;

  // Run shape
  localparam int RANDOM_CHUNK   = 200;   // bytes per random phase
  localparam int HOLD_CYCLES    = 200;   // long out-side stall
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int TAIL_CYCLES    = 16;    // settle time after the last word

  // Upper-half code page bytes and the glyphs they fold onto
  localparam logic [BYTE_W-1:0] BYTE_DEL    = 8'h7F;
  localparam logic [BYTE_W-1:0] CP_VBAR     = 8'hB3;
  localparam logic [BYTE_W-1:0] CP_VBAR_DBL = 8'hBA;
  localparam logic [BYTE_W-1:0] CP_HBAR     = 8'hC4;
  localparam logic [BYTE_W-1:0] CP_HBAR_DBL = 8'hCD;
  localparam logic [BYTE_W-1:0] CP_SHADE_LO = 8'hB0;
  localparam logic [BYTE_W-1:0] CP_SHADE_HI = 8'hB2;
  localparam logic [BYTE_W-1:0] CP_BOX_LO   = 8'hB4;
  localparam logic [BYTE_W-1:0] CP_BOX_HI   = 8'hDF;

  localparam logic [CODE_W-1:0] GLYPH_BAR   = 7'h7C;
  localparam logic [CODE_W-1:0] GLYPH_DASH  = 7'h2D;
  localparam logic [CODE_W-1:0] GLYPH_HASH  = 7'h23;
  localparam logic [CODE_W-1:0] GLYPH_PLUS  = 7'h2B;
  localparam logic [CODE_W-1:0] GLYPH_BLANK = 7'h20;

  // SGR index (0..7 normal, 8..15 bright) to palette entry
  localparam logic [COLOR_W-1:0] SGR_PALETTE [16] = '{
    4'd0, 4'd2, 4'd5, 4'd7, 4'd6, 4'd4, 4'd3, 4'd1,
    4'd11, 4'd10, 4'd13, 4'd7, 4'd14, 4'd4, 4'd3, 4'd1
  };

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_byte   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CMD_W-1:0]    out_command;
  logic [COL_W-1:0]    out_glyph_col;
  logic [ROW_W-1:0]    out_glyph_row;
  logic [CODE_W-1:0]   out_glyph_code;
  logic [COLOR_W-1:0]  out_glyph_color;
  logic                out_last_of_run;

  ansi_csi_terminal_parser_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_command     (out_command),
    .out_glyph_col   (out_glyph_col),
    .out_glyph_row   (out_glyph_row),
    .out_glyph_code  (out_glyph_code),
    .out_glyph_color (out_glyph_color),
    .out_last_of_run (out_last_of_run)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0] byte_backlog [$];   // bytes waiting for the driver
  result_t           pending_words [$];  // predicted words, oldest first
  int                bytes_queued  = 0;
  int                error_count   = 0;
  int                stuck_cycles  = 0;

  // Idling knobs; the stimulus process sets the enables and hold_asked between phases
  bit                in_idle_en    = 1'b0;
  bit                out_idle_en   = 1'b0;
  int                hold_asked    = 0;
  int                hold_served   = 0;
  int                in_gap        = 0;
  int                out_gap       = 0;

  // Screen model: parser phase, cursor, color and CSI argument collector
  phase_t            term_phase = PH_TEXT;
  logic [COL_W-1:0]  cur_col    = '0;
  logic [ROW_W-1:0]  cur_row    = '0;
  logic [COLOR_W-1:0] cur_fg    = COLOR_WHITE;
  logic [BYTE_W-1:0] csi_arg [NARGS] = '{default: '0};
  int                csi_argc   = 0;
  logic [BYTE_W-1:0] csi_acc    = '0;

  // --------------------------------------------------------------------------
  // Screen model
  // --------------------------------------------------------------------------
  function automatic logic [CODE_W-1:0] fold_glyph(logic [BYTE_W-1:0] b);
    if (b >= BYTE_SPACE && b <= BYTE_TILDE) return b[CODE_W-1:0];
    case (b)
      CP_VBAR, CP_VBAR_DBL: return GLYPH_BAR;
      CP_HBAR, CP_HBAR_DBL: return GLYPH_DASH;
      default: ;
    endcase
    // shading block sits just below the box-drawing range
    if (b >= CP_SHADE_LO && b <= CP_SHADE_HI) return GLYPH_HASH;
    if (b >= CP_BOX_LO && b <= CP_BOX_HI) return GLYPH_PLUS;
    return GLYPH_BLANK;  // DEL, the rest of the upper half
  endfunction

  function automatic void push_word(cmd_t c, logic [COL_W-1:0] col,
                                    logic [ROW_W-1:0] row,
                                    logic [CODE_W-1:0] code,
                                    logic [COLOR_W-1:0] color);
    result_t w;
    w.command     = c;
    w.glyph_col   = col;
    w.glyph_row   = row;
    w.glyph_code  = code;
    w.glyph_color = color;
    w.last_of_run = 1'b0;
    pending_words.push_back(w);
  endfunction

  // Line feed semantics shared by LF and wrap: down a row or scroll.
  function automatic void line_down();
    if (int'(cur_row) < ROWS - 1) cur_row = cur_row + 1'b1;
    else push_word(CMD_SCROLL, '0, '0, '0, '0);
  endfunction

  function automatic void keep_arg();
    if (csi_argc < NARGS) begin
      csi_arg[csi_argc] = csi_acc;
      csi_argc++;
    end
    csi_acc = '0;
  endfunction

  // Missing or zero argument counts as 1.
  function automatic int arg_or_one(int i);
    return (csi_argc > i && csi_arg[i] != '0) ? int'(csi_arg[i]) : 1;
  endfunction

  function automatic void run_csi(logic [BYTE_W-1:0] fin);
    int n, row_n, col_n, v;
    n     = arg_or_one(0);
    row_n = int'(cur_row);
    col_n = int'(cur_col);
    case (fin)
      FIN_UP:    row_n = (row_n >= n) ? row_n - n : 0;
      FIN_DOWN:  row_n = (row_n + n < ROWS) ? row_n + n : ROWS - 1;
      FIN_RIGHT: col_n = (col_n + n < COLS) ? col_n + n : COLS - 1;
      FIN_LEFT:  col_n = (col_n >= n) ? col_n - n : 0;
      FIN_POS, FIN_POS_F: begin
        row_n = arg_or_one(0) - 1;
        col_n = arg_or_one(1) - 1;
        if (row_n >= ROWS) row_n = ROWS - 1;
        if (col_n >= COLS) col_n = COLS - 1;
      end
      FIN_ERASE: begin
        // only a bare J or J with a leading 2 clears; cursor stays put
        if (csi_argc == 0 || csi_arg[0] == ERASE_ALL)
          push_word(CMD_CLEAR, '0, '0, '0, '0);
      end
      FIN_SGR: begin
        if (csi_argc == 0) cur_fg = COLOR_WHITE;
        for (int i = 0; i < csi_argc; i++) begin
          v = int'(csi_arg[i]);
          if (v == int'(SGR_RESET)) cur_fg = COLOR_WHITE;
          else if (v >= int'(SGR_FG_LO) && v <= int'(SGR_FG_HI))
            cur_fg = SGR_PALETTE[v - int'(SGR_FG_LO)];
          else if (v >= int'(SGR_BFG_LO) && v <= int'(SGR_BFG_HI))
            cur_fg = SGR_PALETTE[v - int'(SGR_BFG_LO) + 8];
        end
      end
      default: ;  // unknown final: swallowed
    endcase
    cur_row = ROW_W'(row_n);
    cur_col = COL_W'(col_n);
  endfunction

  // One accepted byte: advance the model and queue the words it causes.
  function automatic void parse_byte(logic [BYTE_W-1:0] b);
    int      first;
    bit      is_digit;
    result_t w;
    first    = pending_words.size();
    is_digit = (b >= BYTE_ZERO && b <= BYTE_NINE);
    case (term_phase)
      PH_TEXT: begin
        if (b == BYTE_ESC) term_phase = PH_ESC;
        else if (b == BYTE_CR) cur_col = '0;
        else if (b == BYTE_LF) line_down();
        else if (b >= BYTE_SPACE) begin
          push_word(CMD_RENDER, cur_col, cur_row, fold_glyph(b), cur_fg);
          if (int'(cur_col) + 1 >= COLS) begin
            cur_col = '0;
            line_down();
          end else begin
            cur_col = cur_col + 1'b1;
          end
        end
      end
      PH_ESC: term_phase = (b == BYTE_LBRK) ? PH_OPEN : PH_TEXT;
      PH_OPEN: begin
        csi_arg  = '{default: '0};
        csi_argc = 0;
        csi_acc  = '0;
        if (is_digit) begin
          csi_acc    = b - BYTE_ZERO;
          term_phase = PH_PARAM;
        end else if (b == BYTE_SEMI) begin
          keep_arg();
          term_phase = PH_PARAM;
        end else begin
          term_phase = PH_TEXT;
          run_csi(b);
        end
      end
      default: begin
        if (is_digit) begin
          // accumulator wraps at 8 bits
          csi_acc = BYTE_W'(int'(csi_acc) * 10 + int'(b - BYTE_ZERO));
        end else if (b == BYTE_SEMI) begin
          keep_arg();
        end else begin
          keep_arg();
          term_phase = PH_TEXT;
          run_csi(b);
        end
      end
    endcase
    if (pending_words.size() > first) begin
      w = pending_words.pop_back();
      w.last_of_run = 1'b1;
      pending_words.push_back(w);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_byte(logic [BYTE_W-1:0] b);
    byte_backlog.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_csi(string body, logic [BYTE_W-1:0] fin);
    push_byte(BYTE_ESC);
    push_byte(BYTE_LBRK);
    for (int i = 0; i < body.len(); i++) push_byte(BYTE_W'(body[i]));
    push_byte(fin);
  endtask

  // Cursor-style argument text: empty, small, large, or past 255.
  function automatic string arg_text();
    int    k, v;
    string s;
    k = $urandom_range(0, 99);
    if (k < 10) return "";
    if (k < 55)      v = $urandom_range(0, 30);
    else if (k < 75) v = $urandom_range(0, 99);
    else if (k < 90) v = $urandom_range(100, 255);
    else             v = $urandom_range(256, 999);
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 9) == 0) s = {"0", s};
    return s;
  endfunction

  // SGR argument text: reset, normal/bright fg, background, empty, junk.
  function automatic string sgr_text();
    int k;
    k = $urandom_range(0, 99);
    if (k < 15) return "0";
    if (k < 45) return $sformatf("%0d", $urandom_range(30, 37));
    if (k < 75) return $sformatf("%0d", $urandom_range(90, 97));
    if (k < 85) return $sformatf("%0d", $urandom_range(40, 47));
    if (k < 90) return "";
    return $sformatf("%0d", $urandom_range(0, 255));
  endfunction

  task automatic add_random_burst();
    int                kind, n;
    string             body;
    logic [BYTE_W-1:0] fin;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      // text run; an occasional long one to force wraps
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      repeat (n) begin
        case ($urandom_range(0, 9))
          0, 1:    push_byte(BYTE_W'($urandom_range(8'h80, 8'hFF)));
          2:       push_byte(BYTE_W'($urandom_range(0, 255)));
          default: push_byte(BYTE_W'($urandom_range(int'(BYTE_SPACE), int'(BYTE_TILDE))));
        endcase
      end
    end else if (kind < 50) begin
      case ($urandom_range(0, 3))
        0:       push_byte(BYTE_CR);
        1, 2:    push_byte(BYTE_LF);
        default: push_byte(BYTE_W'($urandom_range(0, 8'h1F)));
      endcase
    end else if (kind < 85) begin
      // well-formed CSI with random arguments, including surplus ones
      case ($urandom_range(0, 9))
        0:       fin = FIN_UP;
        1:       fin = FIN_DOWN;
        2:       fin = FIN_RIGHT;
        3:       fin = FIN_LEFT;
        4, 8:    fin = FIN_POS;
        5:       fin = FIN_POS_F;
        6:       fin = FIN_ERASE;
        7:       fin = FIN_SGR;
        default: fin = BYTE_W'($urandom_range(8'h40, 8'h7E));
      endcase
      n    = $urandom_range(0, NARGS + 1);
      body = "";
      for (int i = 0; i < n; i++) begin
        if (i > 0) body = {body, ";"};
        if (fin == FIN_SGR) body = {body, sgr_text()};
        else if (fin == FIN_ERASE && i == 0)
          body = {body, $sformatf("%0d", $urandom_range(0, 3))};
        else body = {body, arg_text()};
      end
      push_csi(body, fin);
    end else if (kind < 93) begin
      // ESC followed by a random byte, so rarely a CSI
      push_byte(BYTE_ESC);
      push_byte(BYTE_W'($urandom_range(0, 255)));
    end else begin
      // CSI cut short by arbitrary bytes
      push_byte(BYTE_ESC);
      push_byte(BYTE_LBRK);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 2))
          0:       push_byte(BYTE_W'($urandom_range(int'(BYTE_ZERO), int'(BYTE_NINE))));
          1:       push_byte(BYTE_SEMI);
          default: push_byte(BYTE_W'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  task automatic add_random_chunk();
    int target;
    target = bytes_queued + RANDOM_CHUNK;
    while (bytes_queued < target) add_random_burst();
  endtask

  // Polled on the falling edge so every posedge update has settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (byte_backlog.size() != 0 || in_valid || pending_words.size() != 0);
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Input driver: holds a word until taken, then idles for a gap drawn by pick_gap.
  // The model advances at the accepting edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    logic next_valid;
    next_valid = in_valid;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(in_byte);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (byte_backlog.size() > 0) begin
          in_byte    <= byte_backlog.pop_front();
          next_valid = 1'b1;
          in_gap     = pick_gap(in_idle_en);
        end
      end
    end
    in_valid <= next_valid;
  end

  // --------------------------------------------------------------------------
  // Output monitor: checks each taken word against the oldest prediction,
  // then decides out_ready for the next cycle (random stalls, long hold).
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : word_monitor
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          report_mismatch($sformatf("word with nothing pending, command %0d", out_command));
        end else begin
          want = pending_words.pop_front();
          check_field("command",     int'(out_command),     int'(want.command));
          check_field("glyph_col",   int'(out_glyph_col),   int'(want.glyph_col));
          check_field("glyph_row",   int'(out_glyph_row),   int'(want.glyph_row));
          check_field("glyph_code",  int'(out_glyph_code),  int'(want.glyph_code));
          check_field("glyph_color", int'(out_glyph_color), int'(want.glyph_color));
          check_field("last_of_run", int'(out_last_of_run), int'(want.last_of_run));
        end
      end
      // long hold: the sender keeps offering, the result queue fills up
      if (hold_served != hold_asked) begin
        hold_served++;
        out_gap = HOLD_CYCLES;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap   = pick_gap(out_idle_en);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any handshake means the block hung.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed opener, then three random phases with different
  // idling, one of them under a long receiver hold.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: ignored control, printable ends, DEL, code page folding
    push_byte(8'h00);
    push_byte(BYTE_SPACE);
    push_byte(BYTE_TILDE);
    push_byte(BYTE_DEL);
    push_byte(CP_SHADE_LO);
    push_byte(CP_VBAR);
    push_byte(CP_VBAR_DBL);
    push_byte(CP_HBAR);
    push_byte(CP_HBAR_DBL);
    push_byte(CP_BOX_LO);
    push_byte(CP_BOX_HI);
    push_byte(8'hE0);
    push_byte(8'hFF);
    // escape not followed by a bracket: both bytes swallowed
    push_byte(BYTE_ESC);
    push_byte(BYTE_TILDE);
    // oversized position clamps to the bottom-right cell (255 stays 8-bit)
    push_csi("99;255", FIN_POS);
    // glyph in the last cell wraps on the bottom row: render + scroll
    push_byte(BYTE_TILDE);
    // LF on the bottom row scrolls, CR homes the column
    push_byte(BYTE_LF);
    push_byte(BYTE_CR);
    // bare erase clears the screen
    push_csi("", FIN_ERASE);
    wait_drained();

    // Random, idling on both sides
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    add_random_chunk();
    wait_drained();

    // Random, sender flat out while the receiver holds off for a while
    in_idle_en  = 1'b0;
    out_idle_en = 1'b1;
    add_random_chunk();
    hold_asked++;
    wait_drained();

    // Random, receiver always ready
    in_idle_en  = 1'b1;
    out_idle_en = 1'b0;
    add_random_chunk();
    wait_drained();

    // let any stray extra word surface before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
